/* src/tcw_pkg.sv */
package tcw_pkg;

  localparam int CMD_W       = 2;
  localparam int CHAR_W      = 8;
  localparam int INDEX_W     = 11;
  localparam int ATTR_W      = 8;
  localparam int COL_OUT_W   = 7;
  localparam int ROW_OUT_W   = 5;
  localparam int POS_OUT_W   = 11;
  localparam int CELL_W      = CHAR_W + ATTR_W;

  localparam logic [CHAR_W-1:0] CHAR_BLANK = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT       = 2'd0,
    CMD_BACKSPACE = 2'd1,
    CMD_CLEAR     = 2'd2,
    CMD_READ      = 2'd3
  } cmd_e_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SWEEP,
    ST_FINISH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic item_load;
    logic exec;
    logic rd_issue;
    logic sweep_start;
    logic sweep_run;
    logic out_load;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    cmd_e_t cmd;
    logic   scroll_needed;
    logic   sweep_done;
    logic   out_free;
  } sts_t;

endpackage

/* src/tcw_if.sv */
interface tcw_in_if import tcw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [CHAR_W-1:0]  char_code;
  logic [INDEX_W-1:0] cell_index;

  modport source (output valid, cmd, char_code, cell_index, input ready);
  modport sink   (input valid, cmd, char_code, cell_index, output ready);
endinterface

interface tcw_out_if import tcw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CHAR_W-1:0]    cell_char;
  logic [ATTR_W-1:0]    cell_attr;
  logic [COL_OUT_W-1:0] cursor_col;
  logic [ROW_OUT_W-1:0] cursor_row;
  logic [POS_OUT_W-1:0] cursor_pos;
  logic                 scrolled;

  modport source (output valid, cell_char, cell_attr, cursor_col, cursor_row, cursor_pos,
                  scrolled, input ready);
  modport sink   (input valid, cell_char, cell_attr, cursor_col, cursor_row, cursor_pos,
                  scrolled, output ready);
endinterface

interface tcw_cfg_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ATTR_W-1:0] text_attribute;

  modport source (output valid, text_attribute, input ready);
  modport sink   (input valid, text_attribute, output ready);
endinterface

/* src/tcw_ctrl.sv */
module tcw_ctrl import tcw_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output ctl_t ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.item_load = 1'b1;
          state_next    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (sts.cmd)
          CMD_PUT, CMD_BACKSPACE: begin
            ctl.exec = 1'b1;
            if (sts.scroll_needed) begin
              ctl.sweep_start = 1'b1;
              state_next      = ST_SWEEP;
            end else if (sts.out_free) begin
              ctl.out_load = 1'b1;
              state_next   = ST_IDLE;
            end else begin
              state_next = ST_FINISH;
            end
          end
          CMD_CLEAR: begin
            ctl.sweep_start = 1'b1;
            state_next      = ST_SWEEP;
          end
          default: begin
            ctl.rd_issue = 1'b1;
            state_next   = ST_READ;
          end
        endcase
      end
      ST_READ: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_SWEEP: begin
        ctl.sweep_run = 1'b1;
        if (sts.sweep_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* src/tcw_datapath.sv */
module tcw_datapath import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ctl_t                 ctl,
  output sts_t                 sts,
  input  logic [CMD_W-1:0]     cmd,
  input  logic [CHAR_W-1:0]    char_code,
  input  logic [INDEX_W-1:0]   cell_index,
  input  logic                 cfg_we,
  input  logic [ATTR_W-1:0]    cfg_attr,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [CHAR_W-1:0]    cell_char,
  output logic [ATTR_W-1:0]    cell_attr,
  output logic [COL_OUT_W-1:0] cursor_col,
  output logic [ROW_OUT_W-1:0] cursor_row,
  output logic [POS_OUT_W-1:0] cursor_pos,
  output logic                 scrolled
);

  localparam int CELLS    = COLUMNS * ROWS;
  localparam int CW       = $clog2(COLUMNS);
  localparam int RW       = $clog2(ROWS);
  localparam int AW       = $clog2(CELLS);
  localparam int PW       = $clog2(CELLS + 1);
  localparam int LAST_POS = (ROWS - 1) * COLUMNS;
  localparam int COPY_END = CELLS - COLUMNS;

  logic [CELL_W-1:0] mem [CELLS];

  // item registers
  cmd_e_t             cmd_q;
  logic [CHAR_W-1:0]  char_q;
  logic [INDEX_W-1:0] idx_q;
  logic [ATTR_W-1:0]  attr;

  // cursor
  logic [CW-1:0] col, col_next;
  logic [RW-1:0] row, row_next;
  logic [AW-1:0] pos, pos_next;
  logic          scroll_q;

  // cell write from put / backspace
  logic              cell_we;
  logic [AW-1:0]     cell_addr;
  logic [CELL_W-1:0] cell_wdata;
  logic              scroll_needed;

  // sweep engine: clear blanks, scroll copies row below then blanks bottom row
  logic [PW-1:0]     ptr;
  logic              copy_mode;
  logic              issue;
  logic              copy_rd;
  logic              wr_pend;
  logic [AW-1:0]     wr_addr_d;
  logic              wr_copy_d;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] rdata;

  logic [CELL_W-1:0] blank;
  logic              in_range;
  logic              last_row;
  logic              is_nl;

  assign blank    = {attr, CHAR_BLANK};
  assign in_range = 32'(idx_q) < CELLS;
  assign last_row = (row == RW'(ROWS - 1));
  assign is_nl    = char_q inside {CHAR_NL, CHAR_CR};

  always_comb begin
    col_next      = col;
    row_next      = row;
    pos_next      = pos;
    cell_we       = 1'b0;
    cell_addr     = pos;
    cell_wdata    = {attr, char_q};
    scroll_needed = 1'b0;
    case (cmd_q)
      CMD_PUT: begin
        if (is_nl) begin
          col_next = '0;
          if (last_row) begin
            scroll_needed = 1'b1;
            pos_next      = AW'(LAST_POS);
          end else begin
            row_next = row + 1'b1;
            pos_next = pos - AW'(col) + AW'(COLUMNS);
          end
        end else begin
          cell_we = 1'b1;
          if (col == CW'(COLUMNS - 1)) begin
            col_next = '0;
            if (last_row) begin
              scroll_needed = 1'b1;
              pos_next      = AW'(LAST_POS);
            end else begin
              row_next = row + 1'b1;
              pos_next = pos + 1'b1;
            end
          end else begin
            col_next = col + 1'b1;
            pos_next = pos + 1'b1;
          end
        end
      end
      CMD_BACKSPACE: begin
        if (col != '0 || row != '0) begin
          cell_we    = 1'b1;
          cell_wdata = blank;
          // previous cell is always pos - 1, wrapping rows included
          pos_next   = pos - 1'b1;
          cell_addr  = pos - 1'b1;
          if (col != '0) begin
            col_next = col - 1'b1;
          end else begin
            col_next = CW'(COLUMNS - 1);
            row_next = row - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.item_load) begin
      cmd_q  <= cmd_e_t'(cmd);
      char_q <= char_code;
      idx_q  <= cell_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attr     <= ATTR_RESET;
      col      <= '0;
      row      <= '0;
      pos      <= '0;
      scroll_q <= 1'b0;
    end else begin
      if (cfg_we) begin
        attr <= cfg_attr;
      end
      if (ctl.item_load) begin
        scroll_q <= 1'b0;
      end else if (ctl.exec) begin
        col      <= col_next;
        row      <= row_next;
        pos      <= pos_next;
        scroll_q <= scroll_needed;
      end
    end
  end

  // sweep sequencing
  assign issue   = ctl.sweep_run && (ptr != PW'(CELLS));
  assign copy_rd = issue && copy_mode && (ptr < PW'(COPY_END));

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      copy_mode <= 1'b0;
      wr_pend   <= 1'b0;
    end else begin
      if (ctl.sweep_start) begin
        ptr       <= '0;
        copy_mode <= (cmd_q != CMD_CLEAR);
      end else if (issue) begin
        ptr <= ptr + 1'b1;
      end
      wr_pend <= issue;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_d <= AW'(ptr);
    wr_copy_d <= copy_rd;
  end

  // memory ports
  always_comb begin
    if (wr_pend) begin
      mem_we    = 1'b1;
      mem_waddr = wr_addr_d;
      mem_wdata = wr_copy_d ? rdata : blank;
    end else begin
      mem_we    = ctl.exec && cell_we;
      mem_waddr = cell_addr;
      mem_wdata = cell_wdata;
    end
    if (copy_rd) begin
      mem_re    = 1'b1;
      mem_raddr = AW'(ptr) + AW'(COLUMNS);
    end else begin
      mem_re    = ctl.rd_issue && in_range;
      mem_raddr = AW'(idx_q);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      if (cmd_q == CMD_READ && in_range) begin
        cell_char <= rdata[CHAR_W-1:0];
        cell_attr <= rdata[CELL_W-1:CHAR_W];
      end else begin
        cell_char <= '0;
        cell_attr <= '0;
      end
      cursor_col <= COL_OUT_W'(ctl.exec ? col_next : col);
      cursor_row <= ROW_OUT_W'(ctl.exec ? row_next : row);
      cursor_pos <= POS_OUT_W'(ctl.exec ? pos_next : pos);
      scrolled   <= ctl.exec ? scroll_needed : scroll_q;
    end
  end

  assign sts.cmd           = cmd_q;
  assign sts.scroll_needed = scroll_needed;
  assign sts.sweep_done    = (ptr == PW'(CELLS)) && !wr_pend;
  assign sts.out_free      = !out_valid || out_ready;

endmodule

/* src/text_console_writer.sv */
// Sequence: put and backspace load the result from EXEC, reads from READ after EXEC,
// clear and scrolling puts from FINISH after the sweep; any result waits in FINISH while the output is full.
// Throughput: a new item is accepted only in IDLE, once the previous one has loaded
// its result; clear and scrolling puts sweep every cell, one cell per cycle.
// Reset: cursor at origin, attribute 7, output empty; screen contents are
// undefined until a clear is issued.
module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic        clk,
  input logic        rst,
  tcw_in_if.sink     req,
  tcw_out_if.source  rsp,
  tcw_cfg_if.sink    cfg
);

  ctl_t ctl;
  sts_t sts;
  logic in_ready;

  assign req.ready = in_ready;
  assign cfg.ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .cmd        (req.cmd),
    .char_code  (req.char_code),
    .cell_index (req.cell_index),
    .cfg_we     (cfg.valid),
    .cfg_attr   (cfg.text_attribute),
    .out_ready  (rsp.ready),
    .out_valid  (rsp.valid),
    .cell_char  (rsp.cell_char),
    .cell_attr  (rsp.cell_attr),
    .cursor_col (rsp.cursor_col),
    .cursor_row (rsp.cursor_row),
    .cursor_pos (rsp.cursor_pos),
    .scrolled   (rsp.scrolled)
  );

  // no new item enters while the screen pass is running
  assert property (@(posedge clk) disable iff (rst) ctl.sweep_run |-> !in_ready)
    else $error("item accepted during screen pass");

  // the result register is only loaded when its previous item is gone
  assert property (@(posedge clk) disable iff (rst) ctl.out_load |-> sts.out_free)
    else $error("result overwritten before taken");

  // a scroll always leaves the cursor at column 0 of the bottom row
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.scrolled |->
      rsp.cursor_col == '0 && rsp.cursor_row == ROW_OUT_W'(ROWS - 1))
    else $error("scroll left cursor off the bottom row");

endmodule
